### design/lfu_pkg.sv
// shared types and constants for the lfu slot table
package lfu_pkg;

   localparam int COUNT_BITS = 16;
   localparam int STAMP_BITS = 32;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic tok;
      logic hit;
      logic have_empty;
   } scan_flags_type;

   typedef struct packed {
      logic en;
      logic install;
   } write_cmd_type;

endpackage

### design/lfu_cell.sv
// one slot of the table: holds its entry and forwards the search packet
module lfu_cell #(
   parameter int ID_BITS    = 8,
   parameter int SLOT_BITS  = 5,
   parameter int NBITS      = 6,
   parameter int CELL_INDEX = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [NBITS-1:0]                      active_n,
   input  lfu_pkg::write_cmd_type                wr_cmd,
   input  logic [SLOT_BITS-1:0]                  wr_slot,
   input  logic [ID_BITS-1:0]                    wr_id,
   input  logic [lfu_pkg::STAMP_BITS-1:0]        wr_stamp,
   input  lfu_pkg::scan_flags_type               flags_i,
   input  logic [ID_BITS-1:0]                    id_i,
   input  logic [SLOT_BITS-1:0]                  hit_slot_i,
   input  logic [lfu_pkg::COUNT_BITS-1:0]        hit_uses_i,
   input  logic [SLOT_BITS-1:0]                  empty_slot_i,
   input  logic [SLOT_BITS-1:0]                  best_slot_i,
   input  logic [lfu_pkg::COUNT_BITS-1:0]        best_uses_i,
   input  logic [lfu_pkg::STAMP_BITS-1:0]        best_stamp_i,
   input  logic [ID_BITS-1:0]                    best_id_i,
   output lfu_pkg::scan_flags_type               flags_o,
   output logic [ID_BITS-1:0]                    id_o,
   output logic [SLOT_BITS-1:0]                  hit_slot_o,
   output logic [lfu_pkg::COUNT_BITS-1:0]        hit_uses_o,
   output logic [SLOT_BITS-1:0]                  empty_slot_o,
   output logic [SLOT_BITS-1:0]                  best_slot_o,
   output logic [lfu_pkg::COUNT_BITS-1:0]        best_uses_o,
   output logic [lfu_pkg::STAMP_BITS-1:0]        best_stamp_o,
   output logic [ID_BITS-1:0]                    best_id_o
);

   localparam logic [SLOT_BITS-1:0] SELF = SLOT_BITS'(CELL_INDEX);

   logic                            valid_ff;
   logic [ID_BITS-1:0]              ident_ff;
   logic [lfu_pkg::COUNT_BITS-1:0]  uses_ff;
   logic [lfu_pkg::STAMP_BITS-1:0]  stamp_ff;

   lfu_pkg::scan_flags_type         flags_ff, flags_in;
   logic [ID_BITS-1:0]              id_ff;
   logic [SLOT_BITS-1:0]            hit_slot_ff, hit_slot_in;
   logic [lfu_pkg::COUNT_BITS-1:0]  hit_uses_ff, hit_uses_in;
   logic [SLOT_BITS-1:0]            empty_slot_ff, empty_slot_in;
   logic [SLOT_BITS-1:0]            best_slot_ff, best_slot_in;
   logic [lfu_pkg::COUNT_BITS-1:0]  best_uses_ff, best_uses_in;
   logic [lfu_pkg::STAMP_BITS-1:0]  best_stamp_ff, best_stamp_in;
   logic [ID_BITS-1:0]              best_id_ff, best_id_in;

   logic active;
   logic take_best;
   logic wr_here;

   assign active  = NBITS'(CELL_INDEX) < active_n;
   assign wr_here = wr_cmd.en && (wr_slot == SELF);

   always_comb begin
      take_best = (CELL_INDEX == 0) ||
                  (active && valid_ff &&
                   ((uses_ff < best_uses_i) ||
                    ((uses_ff == best_uses_i) && (stamp_ff < best_stamp_i))));
      flags_in      = flags_i;
      hit_slot_in   = hit_slot_i;
      hit_uses_in   = hit_uses_i;
      empty_slot_in = empty_slot_i;
      best_slot_in  = best_slot_i;
      best_uses_in  = best_uses_i;
      best_stamp_in = best_stamp_i;
      best_id_in    = best_id_i;
      if (active && valid_ff && !flags_i.hit && (ident_ff == id_i)) begin
         flags_in.hit = 1'b1;
         hit_slot_in  = SELF;
         hit_uses_in  = uses_ff;
      end
      if (active && !valid_ff && !flags_i.have_empty) begin
         flags_in.have_empty = 1'b1;
         empty_slot_in       = SELF;
      end
      if (take_best) begin
         best_slot_in  = SELF;
         best_uses_in  = uses_ff;
         best_stamp_in = stamp_ff;
         best_id_in    = ident_ff;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_here && wr_cmd.install) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_here) begin
         stamp_ff <= wr_stamp;
         if (wr_cmd.install) begin
            ident_ff <= wr_id;
            uses_ff  <= lfu_pkg::COUNT_BITS'(1);
         end else if (uses_ff != lfu_pkg::COUNT_MAX) begin
            uses_ff <= uses_ff + lfu_pkg::COUNT_BITS'(1);
         end
      end
   end

   // search packet
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_i;
      hit_slot_ff   <= hit_slot_in;
      hit_uses_ff   <= hit_uses_in;
      empty_slot_ff <= empty_slot_in;
      best_slot_ff  <= best_slot_in;
      best_uses_ff  <= best_uses_in;
      best_stamp_ff <= best_stamp_in;
      best_id_ff    <= best_id_in;
   end

   assign flags_o      = flags_ff;
   assign id_o         = id_ff;
   assign hit_slot_o   = hit_slot_ff;
   assign hit_uses_o   = hit_uses_ff;
   assign empty_slot_o = empty_slot_ff;
   assign best_slot_o  = best_slot_ff;
   assign best_uses_o  = best_uses_ff;
   assign best_stamp_o = best_stamp_ff;
   assign best_id_o    = best_id_ff;

endmodule

### design/lfu_slot_replacement.sv
// top level of the lfu slot table with oldest-stamp tie break
//
//   channel   direction   handshake                      payload
//   req       in          req_valid / req_ready          req_candidate_id
//   rsp       out         rsp_valid / rsp_ready          slot, hit, evict, evicted id, count
//   csr       in          psel / penable / pwrite        paddr, pwdata, prdata
//
// an item walks the row of MAX_SLOTS cells, one cell per cycle, then the scan state
// registers the decision and the write state writes back once the result register is free
// one item is searched at a time; the next is taken as soon as the write is done
// the result register lets the next item start while a result waits on rsp_ready
// synchronous reset clears valid bits, time and the packet tokens; active_slots to 32
module lfu_slot_replacement #(
   parameter int MAX_SLOTS = 32,
   parameter int ID_BITS   = 8,
   localparam int SLOT_BITS = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ID_BITS-1:0]              req_candidate_id,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [SLOT_BITS-1:0]            rsp_slot_index,
   output logic                            rsp_was_hit,
   output logic                            rsp_did_evict,
   output logic [ID_BITS-1:0]              rsp_evicted_id,
   output logic [lfu_pkg::COUNT_BITS-1:0]  rsp_new_count,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [1:0]                      paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int NBITS = $clog2(MAX_SLOTS + 1);
   localparam logic [1:0] ADDR_ACTIVE_SLOTS = 2'd0;
   localparam logic [5:0] ACTIVE_RESET = 6'd32;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE} state_type;

   state_type                       state_ff, state_in;
   logic [5:0]                      active_ff;
   logic [NBITS-1:0]                active_n;
   logic [lfu_pkg::STAMP_BITS-1:0]  time_now_ff, time_now_in;

   logic [SLOT_BITS-1:0]            res_slot_ff, res_slot_in;
   logic                            res_hit_ff, res_hit_in;
   logic                            res_evict_ff, res_evict_in;
   logic [ID_BITS-1:0]              res_gone_ff, res_gone_in;
   logic [ID_BITS-1:0]              res_id_ff, res_id_in;
   logic [lfu_pkg::COUNT_BITS-1:0]  res_count_ff, res_count_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [SLOT_BITS-1:0]            rsp_slot_ff, rsp_slot_in;
   logic                            rsp_hit_ff, rsp_hit_in;
   logic                            rsp_evict_ff, rsp_evict_in;
   logic [ID_BITS-1:0]              rsp_gone_ff, rsp_gone_in;
   logic [lfu_pkg::COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;

   logic                            accept;
   logic                            out_free;
   lfu_pkg::write_cmd_type          wr_cmd;

   lfu_pkg::scan_flags_type         flags_w      [0:MAX_SLOTS];
   logic [ID_BITS-1:0]              id_w         [0:MAX_SLOTS];
   logic [SLOT_BITS-1:0]            hit_slot_w   [0:MAX_SLOTS];
   logic [lfu_pkg::COUNT_BITS-1:0]  hit_uses_w   [0:MAX_SLOTS];
   logic [SLOT_BITS-1:0]            empty_slot_w [0:MAX_SLOTS];
   logic [SLOT_BITS-1:0]            best_slot_w  [0:MAX_SLOTS];
   logic [lfu_pkg::COUNT_BITS-1:0]  best_uses_w  [0:MAX_SLOTS];
   logic [lfu_pkg::STAMP_BITS-1:0]  best_stamp_w [0:MAX_SLOTS];
   logic [ID_BITS-1:0]              best_id_w    [0:MAX_SLOTS];

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (psel && penable && pwrite && (paddr == ADDR_ACTIVE_SLOTS)) begin
         active_ff <= pwdata[5:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_ACTIVE_SLOTS) ? 32'(active_ff) : 32'd0;

   always_comb begin
      if (active_ff == 6'd0) begin
         active_n = NBITS'(1);
      end else if (int'(active_ff) > MAX_SLOTS) begin
         active_n = NBITS'(MAX_SLOTS);
      end else begin
         active_n = NBITS'(active_ff);
      end
   end

   // cell row
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign flags_w[0]      = '{tok: accept, hit: 1'b0, have_empty: 1'b0};
   assign id_w[0]         = req_candidate_id;
   assign hit_slot_w[0]   = '0;
   assign hit_uses_w[0]   = '0;
   assign empty_slot_w[0] = '0;
   assign best_slot_w[0]  = '0;
   assign best_uses_w[0]  = '0;
   assign best_stamp_w[0] = '0;
   assign best_id_w[0]    = '0;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign wr_cmd.en      = (state_ff == ST_WRITE) && out_free;
   assign wr_cmd.install = !res_hit_ff;

   for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
      lfu_cell #(
         .ID_BITS    (ID_BITS),
         .SLOT_BITS  (SLOT_BITS),
         .NBITS      (NBITS),
         .CELL_INDEX (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .active_n     (active_n),
         .wr_cmd       (wr_cmd),
         .wr_slot      (res_slot_ff),
         .wr_id        (res_id_ff),
         .wr_stamp     (time_now_ff),
         .flags_i      (flags_w[k]),
         .id_i         (id_w[k]),
         .hit_slot_i   (hit_slot_w[k]),
         .hit_uses_i   (hit_uses_w[k]),
         .empty_slot_i (empty_slot_w[k]),
         .best_slot_i  (best_slot_w[k]),
         .best_uses_i  (best_uses_w[k]),
         .best_stamp_i (best_stamp_w[k]),
         .best_id_i    (best_id_w[k]),
         .flags_o      (flags_w[k+1]),
         .id_o         (id_w[k+1]),
         .hit_slot_o   (hit_slot_w[k+1]),
         .hit_uses_o   (hit_uses_w[k+1]),
         .empty_slot_o (empty_slot_w[k+1]),
         .best_slot_o  (best_slot_w[k+1]),
         .best_uses_o  (best_uses_w[k+1]),
         .best_stamp_o (best_stamp_w[k+1]),
         .best_id_o    (best_id_w[k+1])
      );
   end

   // control
   always_comb begin
      state_in     = state_ff;
      time_now_in  = time_now_ff;
      res_slot_in  = res_slot_ff;
      res_hit_in   = res_hit_ff;
      res_evict_in = res_evict_ff;
      res_gone_in  = res_gone_ff;
      res_id_in    = res_id_ff;
      res_count_in = res_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_evict_in = rsp_evict_ff;
      rsp_gone_in  = rsp_gone_ff;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (flags_w[MAX_SLOTS].tok) begin
               state_in     = ST_WRITE;
               res_id_in    = id_w[MAX_SLOTS];
               res_hit_in   = flags_w[MAX_SLOTS].hit;
               res_evict_in = 1'b0;
               res_gone_in  = '0;
               res_count_in = lfu_pkg::COUNT_BITS'(1);
               priority if (flags_w[MAX_SLOTS].hit) begin
                  res_slot_in = hit_slot_w[MAX_SLOTS];
                  if (hit_uses_w[MAX_SLOTS] != lfu_pkg::COUNT_MAX) begin
                     res_count_in = hit_uses_w[MAX_SLOTS] + lfu_pkg::COUNT_BITS'(1);
                  end else begin
                     res_count_in = lfu_pkg::COUNT_MAX;
                  end
               end else if (flags_w[MAX_SLOTS].have_empty) begin
                  res_slot_in = empty_slot_w[MAX_SLOTS];
               end else begin
                  res_slot_in  = best_slot_w[MAX_SLOTS];
                  res_evict_in = 1'b1;
                  res_gone_in  = best_id_w[MAX_SLOTS];
               end
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               time_now_in  = time_now_ff + lfu_pkg::STAMP_BITS'(1);
               rsp_valid_in = 1'b1;
               rsp_slot_in  = res_slot_ff;
               rsp_hit_in   = res_hit_ff;
               rsp_evict_in = res_evict_ff;
               rsp_gone_in  = res_gone_ff;
               rsp_count_in = res_count_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_now_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_now_ff  <= time_now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_slot_ff  <= res_slot_in;
      res_hit_ff   <= res_hit_in;
      res_evict_ff <= res_evict_in;
      res_gone_ff  <= res_gone_in;
      res_id_ff    <= res_id_in;
      res_count_ff <= res_count_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_evict_ff <= rsp_evict_in;
      rsp_gone_ff  <= rsp_gone_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_was_hit    = rsp_hit_ff;
   assign rsp_did_evict  = rsp_evict_ff;
   assign rsp_evicted_id = rsp_gone_ff;
   assign rsp_new_count  = rsp_count_ff;

`ifndef ASSERT_OFF
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      flags_w[MAX_SLOTS].tok |-> (state_ff == ST_SCAN))
      else $error("search packet left the row outside a scan");

   a_write_gives_item: assert property (@(posedge clock) disable iff (reset)
      wr_cmd.en |=> rsp_valid)
      else $error("write back without a result item");

   a_evict_not_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_did_evict) |-> !rsp_was_hit)
      else $error("eviction reported on a hit");

   a_miss_count_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_was_hit) |-> (rsp_new_count == lfu_pkg::COUNT_BITS'(1)))
      else $error("installed entry count is not one");
`endif

endmodule

### verif/tb.sv
// testbench for the lfu slot table: predicts each placement and checks every result
`timescale 1ns / 100ps

typedef struct packed {
   logic [4:0]                     slot;
   logic                           hit;
   logic                           evict;
   logic [7:0]                     gone;
   logic [lfu_pkg::COUNT_BITS-1:0] count;
} placement_type;

class slot_table_board;
   bit [5:0]                     active_slots;
   bit [7:0]                     slot_id [32];
   bit [lfu_pkg::COUNT_BITS-1:0] slot_uses [32];
   bit [lfu_pkg::STAMP_BITS-1:0] slot_stamp [32];
   bit                           slot_used [32];
   bit [lfu_pkg::STAMP_BITS-1:0] tick;
   placement_type                pending_placements [$];
   int                           errors, lookups, hits, fills, evictions, peak_uses;

   function new();
      active_slots = 6'd32;
      tick = '0;
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
      end
      errors = 0;
      lookups = 0;
      hits = 0;
      fills = 0;
      evictions = 0;
      peak_uses = 0;
   endfunction

   function void set_active(bit [5:0] value);
      active_slots = value;
   endfunction

   function int outstanding();
      return pending_placements.size();
   endfunction

   function void note_lookup(bit [7:0] id);
      int span, i, best, empty;
      bit found, have_empty;
      placement_type p;
      span = (active_slots == 0) ? 1 : ((active_slots > 32) ? 32 : active_slots);
      p = '0;
      found = 1'b0;
      have_empty = 1'b0;
      empty = 0;
      for (i = 0; i < span; i++) begin
         if (slot_used[i]) begin
            if (!found && slot_id[i] == id) begin
               found = 1'b1;
               p.slot = 5'(i);
            end
         end else if (!have_empty) begin
            have_empty = 1'b1;
            empty = i;
         end
      end
      if (found) begin
         if (slot_uses[p.slot] < lfu_pkg::COUNT_MAX) slot_uses[p.slot] += 1;
         slot_stamp[p.slot] = tick;
         hits++;
      end else begin
         if (have_empty) begin
            p.slot = 5'(empty);
            fills++;
         end else begin
            best = 0;
            for (i = 1; i < span; i++) begin
               if (slot_uses[i] < slot_uses[best] ||
                   (slot_uses[i] == slot_uses[best] && slot_stamp[i] < slot_stamp[best]))
                  best = i;
            end
            p.slot = 5'(best);
            p.evict = 1'b1;
            p.gone = slot_id[best];
            evictions++;
         end
         slot_id[p.slot] = id;
         slot_uses[p.slot] = 1;
         slot_stamp[p.slot] = tick;
         slot_used[p.slot] = 1'b1;
      end
      tick += 1;
      p.hit = found;
      p.count = slot_uses[p.slot];
      if (int'(p.count) > peak_uses) peak_uses = int'(p.count);
      lookups++;
      pending_placements.push_back(p);
   endfunction

   function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, what, want, got);
         errors++;
      end
   endfunction

   function void check_placement(logic [4:0] slot, logic hit, logic evict,
                                 logic [7:0] gone, logic [lfu_pkg::COUNT_BITS-1:0] count);
      placement_type p;
      if (pending_placements.size() == 0) begin
         $display("%0t: unexpected result slot %0h hit %0h count %0h",
                  $time, slot, hit, count);
         errors++;
         return;
      end
      p = pending_placements.pop_front();
      compare("slot_index", 32'(p.slot), 32'(slot));
      compare("was_hit", 32'(p.hit), 32'(hit));
      compare("did_evict", 32'(p.evict), 32'(evict));
      compare("evicted_id", 32'(p.gone), 32'(gone));
      compare("new_count", 32'(p.count), 32'(count));
   endfunction
endclass

module tb;
   localparam logic [1:0] ACTIVE_SLOTS_ADDR = 2'd0;
   localparam logic [1:0] UNMAPPED_ADDR     = 2'd1;
   localparam int         PHASE_ITEMS       = 92;

   typedef enum int {DRAIN_ALWAYS, DRAIN_RANDOM, DRAIN_BLOCKED} drain_mode_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [7:0]                     req_candidate_id;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [4:0]                     rsp_slot_index;
   logic                           rsp_was_hit;
   logic                           rsp_did_evict;
   logic [7:0]                     rsp_evicted_id;
   logic [lfu_pkg::COUNT_BITS-1:0] rsp_new_count;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [1:0]                     paddr;
   logic [31:0]                    pwdata;
   logic [31:0]                    prdata;
   logic                           pready;

   slot_table_board sb;
   drain_mode_type  drain_mode;
   int              drain_cycle;
   int              config_writes;
   bit [7:0]        id_pool [64];
   int              pool_size;
   int              hot_size;

   lfu_slot_replacement u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_candidate_id (req_candidate_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_was_hit      (rsp_was_hit),
      .rsp_did_evict    (rsp_did_evict),
      .rsp_evicted_id   (rsp_evicted_id),
      .rsp_new_count    (rsp_new_count),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      drain_mode = DRAIN_ALWAYS;
      drain_cycle = 0;
      forever begin
         @(negedge clock);
         drain_cycle++;
         if (drain_cycle % 256 == 0) drain_mode = drain_mode_type'($urandom_range(0, 2));
         case (drain_mode)
            DRAIN_ALWAYS:  rsp_ready = 1'b1;
            DRAIN_RANDOM:  rsp_ready = ($urandom_range(0, 2) != 0);
            DRAIN_BLOCKED: rsp_ready = ((drain_cycle % 97) >= 37);
            default:       rsp_ready = 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_placement(rsp_slot_index, rsp_was_hit, rsp_did_evict,
                            rsp_evicted_id, rsp_new_count);
   end

   task automatic send_item(bit [7:0] id);
      @(negedge clock);
      req_valid = 1'b1;
      req_candidate_id = id;
      do @(posedge clock); while (!req_ready);
      sb.note_lookup(id);
   endtask

   task automatic idle(int cycles);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] addr, logic [31:0] data);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      if (addr == ACTIVE_SLOTS_ADDR) sb.set_active(data[5:0]);
      config_writes++;
   endtask

   task automatic csr_check();
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = ACTIVE_SLOTS_ADDR;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.compare("active_slots readback", {26'd0, sb.active_slots}, {26'd0, prdata[5:0]});
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic set_table_size(bit [5:0] value);
      csr_write(ACTIVE_SLOTS_ADDR, {$urandom} & 32'hFFFF_FFC0 | value);
      csr_check();
   endtask

   function automatic bit [7:0] pick_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return id_pool[$urandom_range(0, hot_size - 1)];
      if (r < 88) return id_pool[$urandom_range(0, pool_size - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic bit [5:0] phase_setting(int p);
      case (p)
         0:       return 6'd1;
         1:       return 6'd32;
         2:       return 6'd0;
         3:       return 6'd63;
         4:       return 6'd2;
         5:       return 6'd31;
         6:       return 6'd33;
         default: return 6'($urandom_range(0, 63));
      endcase
   endfunction

   initial begin
      int phase, sent, burst, span, i;
      bit steady;
      bit [5:0] setting;

      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_candidate_id = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      config_writes = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default size, fills and hits at the id extremes
      csr_check();
      send_item(8'h00);
      send_item(8'hFF);
      send_item(8'h00);
      send_item(8'hAA);
      send_item(8'h55);
      send_item(8'hFF);
      wait_drained();

      // two slots: a tie broken by oldest stamp, then evictions by count; hidden slots not searched
      csr_write(ACTIVE_SLOTS_ADDR, 32'hFFFF_FFC2);
      csr_check();
      send_item(8'h00);
      send_item(8'hFF);
      send_item(8'h07);
      send_item(8'h09);
      send_item(8'h0B);
      send_item(8'hAA);
      wait_drained();

      // grow again: stale copies reappear, lowest matching slot wins
      set_table_size(6'd32);
      send_item(8'hAA);
      send_item(8'h55);
      wait_drained();

      // zero acts as one slot
      set_table_size(6'd0);
      send_item(8'h03);
      send_item(8'h03);
      send_item(8'h04);
      wait_drained();

      // write to an unmapped address leaves the size alone
      csr_write(UNMAPPED_ADDR, 32'h0000_0005);
      csr_check();
      send_item(8'h06);
      wait_drained();

      // oversized setting clamps to the full table
      set_table_size(6'd63);
      send_item(8'h80);
      send_item(8'h01);
      send_item(8'hFE);
      wait_drained();

      for (phase = 0; phase < 9; phase++) begin
         setting = phase_setting(phase);
         set_table_size(setting);
         span = (setting == 0) ? 1 : ((setting > 32) ? 32 : setting);
         pool_size = $urandom_range(1, span + span / 2 + 2);
         if (pool_size > 64) pool_size = 64;
         hot_size = (pool_size < 4) ? pool_size : 4;
         for (i = 0; i < pool_size; i++) id_pool[i] = 8'($urandom_range(0, 255));
         steady = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && sent < PHASE_ITEMS) begin
               send_item(pick_id());
               sent++;
               burst--;
            end
            if (!steady && $urandom_range(0, 3) != 0) idle($urandom_range(1, 45));
         end
         wait_drained();
      end

      repeat (40) @(posedge clock);
      $display("covered %0d lookups: %0d hits, %0d fills, %0d evictions, peak count %0d",
               sb.lookups, sb.hits, sb.fills, sb.evictions, sb.peak_uses);
      $display("%0d register writes over table sizes 0 to 63 with stalled and bursty traffic",
               config_writes);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
